// ===== hw/rtl/byte_stuffed_frame_receiver_macros.svh =====
// ----------------------------------------------------------------------------
// Byte-stuffed frame receiver assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef BYTE_STUFFED_FRAME_RECEIVER_MACROS_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_MACROS_SVH

// Generic form with an explicit clock and active-low reset.
`define BSFR_CLK_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Form bound to the block clock and reset.
`define BSFR_ASSERT(lbl, prop, msg) \
    `BSFR_CLK_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== hw/rtl/bsfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-stuffed frame receiver package
// Shared types, constants and the CRC-8 step function.
// ----------------------------------------------------------------------------
package bsfr_pkg;

    localparam int FRAME_BYTES_DEF = 64;
    // Frame length counter width, covering the largest supported buffer.
    localparam int LEN_W = 7;
    localparam int PIDX_W = 6;
    localparam int HEADER_BYTES = 8;
    localparam int HDR_KEEP = 7;
    localparam int CFG_IDX_W = 8;

    localparam logic [7:0] VERSION_ONE = 8'h01;
    localparam int MASTER_BIT = 1;
    localparam int NOTIFY_BIT = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DELIM = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POLY = 8'd3;

    localparam logic [7:0] DELIM_RST = 8'h7E;
    localparam logic [7:0] ESCAPE_RST = 8'h7D;
    localparam logic [7:0] MASK_RST = 8'h20;
    localparam logic [7:0] POLY_RST = 8'h2F;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SHORT       = 3'd1,
        ST_BAD_CRC     = 3'd2,
        ST_BAD_VERSION = 3'd3,
        ST_NOT_MASTER  = 3'd4,
        ST_NOTIFY      = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        US_IDLE,
        US_HDR,
        US_EVAL,
        US_PAY
    } t_unload_state;

    typedef struct packed {
        logic [7:0] delim;
        logic [7:0] escape;
        logic [7:0] mask;
        logic [7:0] poly;
    } t_cfg;

    typedef struct packed {
        logic             fire;
        logic [LEN_W-1:0] len;
        logic [7:0]       crc_chk;
    } t_close;

    // One byte of CRC-8, MSB first.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                               input logic [7:0] data,
                                               input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/bsfr_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame store
// Single-port-write, single-port-read byte memory with registered read data.
// ----------------------------------------------------------------------------
module bsfr_store #(
    parameter int DEPTH = bsfr_pkg::FRAME_BYTES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/bsfr_ingest.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame ingest
// Unstuffs received bytes, keeps the running CRC and writes the frame store.
// ----------------------------------------------------------------------------
module bsfr_ingest #(
    parameter int FRAME_BYTES = bsfr_pkg::FRAME_BYTES_DEF,
    parameter int AW          = $clog2(FRAME_BYTES)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_rx_byte,
    input  bsfr_pkg::t_cfg        i_cfg,
    output logic                  o_wr_en,
    output logic [AW-1:0]         o_wr_addr,
    output logic [7:0]            o_wr_data,
    output bsfr_pkg::t_close      o_close
);

    logic [bsfr_pkg::LEN_W-1:0] r_count, n_count;
    logic                       r_esc, n_esc;
    logic [7:0]                 r_crc, n_crc;
    logic [7:0]                 r_crc_prev, n_crc_prev;
    logic                       store;
    logic [7:0]                 data;

    always_comb begin
        n_count    = r_count;
        n_esc      = r_esc;
        n_crc      = r_crc;
        n_crc_prev = r_crc_prev;
        store      = 1'b0;
        data       = r_esc ? (i_rx_byte ^ i_cfg.mask) : i_rx_byte;
        o_close    = '0;
        o_close.len     = r_count;
        o_close.crc_chk = r_crc_prev;

        if (i_accept) begin
            if (r_esc) begin
                n_esc = 1'b0;
                store = 1'b1;
            end else if (i_rx_byte == i_cfg.delim) begin
                if (r_count != '0) begin
                    o_close.fire = 1'b1;
                    n_count      = '0;
                    n_crc        = '0;
                    n_crc_prev   = '0;
                end
            end else if (i_rx_byte == i_cfg.escape) begin
                n_esc = 1'b1;
            end else begin
                store = 1'b1;
            end
        end

        // Bytes beyond the buffer are dropped and stay out of the CRC.
        if (store && (r_count < bsfr_pkg::LEN_W'(FRAME_BYTES))) begin
            n_crc_prev = r_crc;
            n_crc      = bsfr_pkg::crc8_update(r_crc, data, i_cfg.poly);
            n_count    = r_count + bsfr_pkg::LEN_W'(1);
            o_wr_en    = 1'b1;
        end else begin
            o_wr_en    = 1'b0;
        end
        o_wr_addr = r_count[AW-1:0];
        o_wr_data = data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_esc      <= 1'b0;
            r_crc      <= '0;
            r_crc_prev <= '0;
        end else begin
            r_count    <= n_count;
            r_esc      <= n_esc;
            r_crc      <= n_crc;
            r_crc_prev <= n_crc_prev;
        end
    end

endmodule

// ===== hw/rtl/bsfr_unload.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame unload sequencer
// Reads a closed frame back from the store, checks it and emits the results.
// ----------------------------------------------------------------------------
module bsfr_unload #(
    parameter int FRAME_BYTES = bsfr_pkg::FRAME_BYTES_DEF,
    parameter int AW          = $clog2(FRAME_BYTES)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bsfr_pkg::t_close             i_close,
    input  logic [7:0]                   i_rd_data,
    output logic                         o_rd_en,
    output logic [AW-1:0]                o_rd_addr,
    output logic                         o_busy,
    output logic                         o_strobe,
    output logic [2:0]                   o_frame_status,
    output logic [31:0]                  o_frame_flags,
    output logic [15:0]                  o_frame_profile,
    output logic [7:0]                   o_payload_byte,
    output logic [bsfr_pkg::PIDX_W-1:0]  o_payload_index,
    output logic [bsfr_pkg::PIDX_W-1:0]  o_payload_count,
    output logic                         o_payload_valid,
    output logic                         o_last_of_frame
);

    localparam int LW = bsfr_pkg::LEN_W;
    localparam int PW = bsfr_pkg::PIDX_W;

    bsfr_pkg::t_unload_state r_state, n_state;
    logic [2:0]    r_idx, n_idx;
    logic [PW-1:0] r_pidx, n_pidx;
    logic [PW-1:0] r_plen, n_plen;
    logic [LW-1:0] r_len;
    logic [7:0]    r_crc_chk;
    logic          r_crc_bad;
    logic [7:0]    r_hdr [bsfr_pkg::HDR_KEEP];

    logic              r_stb, n_stb;
    bsfr_pkg::t_status r_status, n_status;
    logic [31:0]       r_flags, n_flags;
    logic [15:0]       r_profile, n_profile;
    logic [7:0]        r_pbyte, n_pbyte;
    logic [PW-1:0]     r_oidx, n_oidx;
    logic [PW-1:0]     r_olen, n_olen;
    logic              r_valid, n_valid;
    logic              r_last, n_last;

    logic [31:0]       flags;
    logic [15:0]       profile;
    logic [PW-1:0]     plen;
    bsfr_pkg::t_status eval_status;

    assign flags   = {r_hdr[4], r_hdr[3], r_hdr[2], r_hdr[1]};
    assign profile = {r_hdr[6], r_hdr[5]};
    assign plen    = PW'(r_len - LW'(bsfr_pkg::HEADER_BYTES));

    always_comb begin
        if (r_crc_bad) begin
            eval_status = bsfr_pkg::ST_BAD_CRC;
        end else if (r_hdr[0] != bsfr_pkg::VERSION_ONE) begin
            eval_status = bsfr_pkg::ST_BAD_VERSION;
        end else if (!flags[bsfr_pkg::MASTER_BIT]) begin
            eval_status = bsfr_pkg::ST_NOT_MASTER;
        end else if (flags[bsfr_pkg::NOTIFY_BIT]) begin
            eval_status = bsfr_pkg::ST_NOTIFY;
        end else begin
            eval_status = bsfr_pkg::ST_OK;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_pidx    = r_pidx;
        n_plen    = r_plen;
        o_rd_en   = 1'b0;
        o_rd_addr = '0;
        n_stb     = 1'b0;
        n_status  = r_status;
        n_flags   = r_flags;
        n_profile = r_profile;
        n_pbyte   = r_pbyte;
        n_oidx    = r_oidx;
        n_olen    = r_olen;
        n_valid   = r_valid;
        n_last    = r_last;

        unique case (r_state)
            bsfr_pkg::US_IDLE: begin
                if (i_close.fire) begin
                    if (i_close.len < LW'(bsfr_pkg::HEADER_BYTES)) begin
                        n_stb     = 1'b1;
                        n_status  = bsfr_pkg::ST_SHORT;
                        n_flags   = '0;
                        n_profile = '0;
                        n_pbyte   = '0;
                        n_oidx    = '0;
                        n_olen    = '0;
                        n_valid   = 1'b0;
                        n_last    = 1'b1;
                    end else begin
                        // Fetch the check byte first, then the header.
                        o_rd_en   = 1'b1;
                        o_rd_addr = AW'(i_close.len - LW'(1));
                        n_idx     = '0;
                        n_state   = bsfr_pkg::US_HDR;
                    end
                end
            end
            bsfr_pkg::US_HDR: begin
                o_rd_en   = 1'b1;
                o_rd_addr = AW'(r_idx);
                n_idx     = r_idx + 3'd1;
                if (r_idx == 3'(bsfr_pkg::HDR_KEEP)) begin
                    n_state = bsfr_pkg::US_EVAL;
                end
            end
            bsfr_pkg::US_EVAL: begin
                n_plen = plen;
                n_pidx = '0;
                if (eval_status != bsfr_pkg::ST_OK || plen == '0) begin
                    n_stb     = 1'b1;
                    n_status  = eval_status;
                    n_flags   = (eval_status == bsfr_pkg::ST_OK) ? flags : '0;
                    n_profile = (eval_status == bsfr_pkg::ST_OK) ? profile : '0;
                    n_pbyte   = '0;
                    n_oidx    = '0;
                    n_olen    = '0;
                    n_valid   = 1'b0;
                    n_last    = 1'b1;
                    n_state   = bsfr_pkg::US_IDLE;
                end else begin
                    n_state = bsfr_pkg::US_PAY;
                end
            end
            bsfr_pkg::US_PAY: begin
                n_stb     = 1'b1;
                n_status  = bsfr_pkg::ST_OK;
                n_flags   = flags;
                n_profile = profile;
                n_pbyte   = i_rd_data;
                n_oidx    = r_pidx;
                n_olen    = r_plen;
                n_valid   = 1'b1;
                n_last    = (r_pidx == r_plen - PW'(1));
                n_pidx    = r_pidx + PW'(1);
                if (n_last) begin
                    n_state = bsfr_pkg::US_IDLE;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = AW'(LW'(r_pidx) + LW'(bsfr_pkg::HEADER_BYTES));
                end
            end
            default: begin
                n_state = bsfr_pkg::US_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsfr_pkg::US_IDLE;
            r_stb   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stb   <= n_stb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_pidx    <= n_pidx;
        r_plen    <= n_plen;
        r_status  <= n_status;
        r_flags   <= n_flags;
        r_profile <= n_profile;
        r_pbyte   <= n_pbyte;
        r_oidx    <= n_oidx;
        r_olen    <= n_olen;
        r_valid   <= n_valid;
        r_last    <= n_last;
        if (r_state == bsfr_pkg::US_IDLE && i_close.fire) begin
            r_len     <= i_close.len;
            r_crc_chk <= i_close.crc_chk;
        end
        if (r_state == bsfr_pkg::US_HDR) begin
            if (r_idx == '0) begin
                r_crc_bad <= (i_rd_data != r_crc_chk);
            end else begin
                r_hdr[r_idx - 3'd1] <= i_rd_data;
            end
        end
    end

    assign o_busy           = (r_state != bsfr_pkg::US_IDLE);
    assign o_strobe         = r_stb;
    assign o_frame_status   = r_status;
    assign o_frame_flags    = r_flags;
    assign o_frame_profile  = r_profile;
    assign o_payload_byte   = r_pbyte;
    assign o_payload_index  = r_oidx;
    assign o_payload_count  = r_olen;
    assign o_payload_valid  = r_valid;
    assign o_last_of_frame  = r_last;

endmodule

// ===== hw/rtl/byte_stuffed_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-stuffed frame receiver
// Deframes a byte-stuffed serial stream, checks the CRC-8 and header of each
// frame, and reports a reject status or the frame's payload bytes.
// ----------------------------------------------------------------------------
// The receiver cannot stall: every result appears on the result ports for one
// clock cycle with o_strobe high and is gone at the next edge, so the consumer
// must take it then. A byte is transferred at an edge with start high and busy
// low. Ordinary data, escape and empty-frame delimiter bytes leave busy low, so
// the next byte can follow without a hold. A delimiter that closes a frame
// shorter than the eight header and check bytes also leaves busy low, and its
// reject result appears in the following cycle. Any longer frame is read back
// through the single read port of the frame store: busy stays high through the
// check byte and header reads, the header evaluation and the payload run of one
// byte per cycle. Every result leaves through one register stage, so a reject
// or empty-payload result of such a frame follows the header evaluation, and
// the payload bytes follow back to back. The store holds no reset state and
// needs no clearing pass, because only bytes written in the current frame are
// ever read back.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_receiver #(
    parameter int FRAME_BYTES = bsfr_pkg::FRAME_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [7:0]                      i_rx_byte,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bsfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                      i_cfg_data,
    output logic                            o_strobe,
    output logic [2:0]                      o_frame_status,
    output logic [31:0]                     o_frame_flags,
    output logic [15:0]                     o_frame_profile,
    output logic [7:0]                      o_payload_byte,
    output logic [bsfr_pkg::PIDX_W-1:0]     o_payload_index,
    output logic [bsfr_pkg::PIDX_W-1:0]     o_payload_count,
    output logic                            o_payload_valid,
    output logic                            o_last_of_frame
);

    // Address width of the frame store follows the buffer size.
    localparam int AW = $clog2(FRAME_BYTES);

    bsfr_pkg::t_cfg   r_cfg;
    bsfr_pkg::t_close close;
    logic             accept;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [7:0]       rd_data;

    assign accept      = start && !busy;
    // Configuration writes are always taken; users must only write while idle.
    assign o_cfg_ready = 1'b1;

    // Configuration registers. Writes to unlisted indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delim  <= bsfr_pkg::DELIM_RST;
            r_cfg.escape <= bsfr_pkg::ESCAPE_RST;
            r_cfg.mask   <= bsfr_pkg::MASK_RST;
            r_cfg.poly   <= bsfr_pkg::POLY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bsfr_pkg::CFG_DELIM:  r_cfg.delim  <= i_cfg_data;
                bsfr_pkg::CFG_ESCAPE: r_cfg.escape <= i_cfg_data;
                bsfr_pkg::CFG_MASK:   r_cfg.mask   <= i_cfg_data;
                bsfr_pkg::CFG_POLY:   r_cfg.poly   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Byte unstuffing, CRC and store writes happen in the transfer cycle.
    bsfr_ingest #(
        .FRAME_BYTES (FRAME_BYTES),
        .AW          (AW)
    ) u_ingest (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (r_cfg),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_close   (close)
    );

    // Frame buffer. Writes and reads never target the same cycle because the
    // first read is on a delimiter, later ones while busy holds off new bytes.
    bsfr_store #(
        .DEPTH (FRAME_BYTES),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Frame close: check byte, header, verdict, then the payload run.
    bsfr_unload #(
        .FRAME_BYTES (FRAME_BYTES),
        .AW          (AW)
    ) u_unload (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_close          (close),
        .i_rd_data        (rd_data),
        .o_rd_en          (rd_en),
        .o_rd_addr        (rd_addr),
        .o_busy           (busy),
        .o_strobe         (o_strobe),
        .o_frame_status   (o_frame_status),
        .o_frame_flags    (o_frame_flags),
        .o_frame_profile  (o_frame_profile),
        .o_payload_byte   (o_payload_byte),
        .o_payload_index  (o_payload_index),
        .o_payload_count  (o_payload_count),
        .o_payload_valid  (o_payload_valid),
        .o_last_of_frame  (o_last_of_frame)
    );

endmodule

// ===== hw/rtl/bsfr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-stuffed frame receiver checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "byte_stuffed_frame_receiver_macros.svh"

module bsfr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic [7:0]                      i_rx_byte,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [bsfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [7:0]                      i_cfg_data,
    input logic                            o_strobe,
    input logic [2:0]                      o_frame_status,
    input logic [31:0]                     o_frame_flags,
    input logic [15:0]                     o_frame_profile,
    input logic [7:0]                      o_payload_byte,
    input logic [bsfr_pkg::PIDX_W-1:0]     o_payload_index,
    input logic [bsfr_pkg::PIDX_W-1:0]     o_payload_count,
    input logic                            o_payload_valid,
    input logic                            o_last_of_frame
);

    // Only defined status codes are reported.
    `BSFR_ASSERT(a_status_range,
        o_strobe |-> o_frame_status <= 3'(bsfr_pkg::ST_NOTIFY),
        "status code out of range")

    // A reject is a single closing result without payload.
    `BSFR_ASSERT(a_reject_alone,
        (o_strobe && o_frame_status != 3'(bsfr_pkg::ST_OK)) |->
            (o_last_of_frame && !o_payload_valid && o_payload_count == '0),
        "reject result malformed")

    // A payload run continues in the next cycle with the next index.
    `BSFR_ASSERT(a_run_contiguous,
        (o_strobe && o_payload_valid && !o_last_of_frame) |=>
            (o_strobe && o_payload_valid &&
             o_payload_index == $past(o_payload_index) + 6'd1),
        "payload run broken")

    // Payload indexes stay below the reported length.
    `BSFR_ASSERT(a_index_bound,
        (o_strobe && o_payload_valid) |-> o_payload_index < o_payload_count,
        "payload index beyond length")

endmodule

bind byte_stuffed_frame_receiver bsfr_checker u_bsfr_checker (.*);
